// ===== rtl/fsat_pkg.sv =====
package fsat_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned KEY_W   = 96;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned ENTRY_W = KEY_W + TIME_W;

  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned LIVE_W  = 7;
  localparam int unsigned CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(64);

  // Register index, taken from the 8-byte-aligned address.
  localparam logic REG_LIMIT   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } scan_state_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [TIME_W-1:0]  timeout;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [LIVE_W-1:0] live;
    logic              decision;
  } res_t;

endpackage

// ===== rtl/flow_session_admission_table.sv =====
// Flow session admission table. Each request carries a 96-bit flow key and a
// timestamp; the block scans its whole session table once per request, frees
// every live session whose last-seen time lies before the request's time by
// more than idle_timeout, then either refreshes a matching session, admits a
// new session into the lowest free slot, or rejects the request when the live
// count has reached session_limit (values above the table depth act as the
// depth). Keys and times sit in one synchronous RAM read once per slot; valid
// bits are flip-flops cleared by reset, so no clearing pass is needed. After
// acceptance, the table scan is set by the single RAM read port, followed by
// a two-stage evaluation, a step in which the scan is seen to be finished
// and a step for the decision and write-back. The next request is accepted
// only in the cycle after the write-back, so scans never see a stale entry.
// A finished result waits in an output register, and a new request may be
// taken while it waits; the write-back of that next request stalls only if
// the earlier result has still not been taken by then. The user must write
// configuration only while no request is in flight; the block itself does
// not enforce this.
module flow_session_admission_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // source_ident[31:0], service_ident[63:32], source_port[79:64],
  // target_port[95:80], now_time[159:96]
  input  logic [159:0]                        s_axis_tdata,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // decision[0], live_count[7:1]
  output logic [7:0]                          m_axis_tdata,
  // Configuration: session_limit at 0x0, idle_timeout at 0x8.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fsat_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [fsat_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [fsat_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  fsat_pkg::cfg_t cfg;
  fsat_pkg::req_t req;
  fsat_pkg::res_t res;
  logic           res_valid;
  logic           out_free;
  logic           m_valid_q;
  fsat_pkg::res_t m_res_q;

  // Flow key laid out as source id, service id, source port, target port.
  assign req.key = s_axis_tdata[95:0];
  assign req.now = s_axis_tdata[159:96];

  fsat_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The output register is free when empty or being drained this cycle.
  assign out_free = !m_valid_q || m_axis_tready;

  fsat_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_req_i    (req),
    .in_ready_o  (s_axis_tready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_res_q.live, m_res_q.decision};

endmodule

// ===== rtl/fsat_ram.sv =====
module fsat_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/fsat_cfg.sv =====
module fsat_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fsat_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [fsat_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [fsat_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output fsat_pkg::cfg_t                     cfg_o
);

  logic [fsat_pkg::LIMIT_W-1:0] limit_q;
  logic [fsat_pkg::TIME_W-1:0]  timeout_q;
  logic                         wr_en;
  logic                         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= fsat_pkg::LIMIT_RST;
      timeout_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        fsat_pkg::REG_LIMIT:   limit_q   <= pwdata[fsat_pkg::LIMIT_W-1:0];
        fsat_pkg::REG_TIMEOUT: timeout_q <= pwdata[fsat_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fsat_pkg::REG_LIMIT:   prdata = fsat_pkg::CFG_DATA_W'(limit_q);
      fsat_pkg::REG_TIMEOUT: prdata = fsat_pkg::CFG_DATA_W'(timeout_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.limit   = limit_q;
  assign cfg_o.timeout = timeout_q;

endmodule

// ===== rtl/fsat_scan.sv =====
module fsat_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fsat_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  input  fsat_pkg::req_t in_req_i,
  output logic           in_ready_o,
  input  logic           out_free_i,
  output logic           res_valid_o,
  output fsat_pkg::res_t res_o
);

  fsat_pkg::scan_state_e state_q, state_d;

  logic [fsat_pkg::KEY_W-1:0]   key_q;
  logic [fsat_pkg::TIME_W-1:0]  now_q;
  logic [fsat_pkg::CNT_W-1:0]   cnt_q;
  logic                         a_vld_q;
  logic [fsat_pkg::IDX_W-1:0]   a_idx_q;
  logic                         b_vld_q;
  logic [fsat_pkg::IDX_W-1:0]   b_idx_q;
  logic                         b_later_q;
  logic [fsat_pkg::TIME_W-1:0]  b_diff_q;
  logic                         b_match_q;
  logic [fsat_pkg::TABLE_DEPTH-1:0] vld_q;
  logic [fsat_pkg::CNT_W-1:0]   live_q;
  logic                         hit_q;
  logic [fsat_pkg::IDX_W-1:0]   hit_idx_q;
  logic                         free_q;
  logic [fsat_pkg::IDX_W-1:0]   free_idx_q;

  logic                         accept;
  logic                         issue;
  logic                         scan_done;
  logic                         commit;
  logic                         b_expire;
  logic                         b_live;
  logic                         full;
  logic                         insert;
  logic                         wr_en;
  logic [fsat_pkg::IDX_W-1:0]   wr_addr;
  logic [fsat_pkg::ENTRY_W-1:0] rd_data;
  logic [fsat_pkg::TIME_W-1:0]  rd_time;
  logic [fsat_pkg::KEY_W-1:0]   rd_key;
  logic [fsat_pkg::CNT_W-1:0]   live_out;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsat_pkg::ST_IDLE:   if (in_valid_i) state_d = fsat_pkg::ST_SCAN;
      fsat_pkg::ST_SCAN:   if (scan_done)  state_d = fsat_pkg::ST_DECIDE;
      fsat_pkg::ST_DECIDE: if (out_free_i) state_d = fsat_pkg::ST_IDLE;
      default:             state_d = fsat_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    scan_done  = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      fsat_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      fsat_pkg::ST_SCAN: begin
        issue     = (cnt_q < fsat_pkg::CNT_W'(fsat_pkg::TABLE_DEPTH));
        scan_done = !issue && !a_vld_q && !b_vld_q;
      end
      fsat_pkg::ST_DECIDE: begin
        commit = out_free_i;
      end
      default: ;
    endcase
  end

  assign accept = in_ready_o && in_valid_i;

  assign rd_time = rd_data[fsat_pkg::TIME_W-1:0];
  assign rd_key  = rd_data[fsat_pkg::ENTRY_W-1:fsat_pkg::TIME_W];

  assign b_expire = vld_q[b_idx_q] && b_later_q && (b_diff_q > cfg_i.timeout);
  assign b_live   = vld_q[b_idx_q] && !b_expire;

  assign full = (fsat_pkg::CMP_W'(live_q) >= fsat_pkg::CMP_W'(cfg_i.limit))
             || (live_q == fsat_pkg::CNT_W'(fsat_pkg::TABLE_DEPTH));

  assign insert   = commit && !hit_q && !full;
  assign wr_en    = commit && (hit_q || !full);
  assign wr_addr  = hit_q ? hit_idx_q : free_idx_q;
  assign live_out = live_q + fsat_pkg::CNT_W'(insert);

  assign res_valid_o    = commit;
  assign res_o.decision = !hit_q && full;
  assign res_o.live     = fsat_pkg::LIVE_W'(live_out);

  fsat_ram #(
    .WIDTH (fsat_pkg::ENTRY_W),
    .DEPTH (fsat_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i ({key_q, now_q}),
    .rd_en_i   (issue),
    .rd_addr_i (cnt_q[fsat_pkg::IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsat_pkg::ST_IDLE;
      cnt_q   <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      vld_q   <= '0;
      live_q  <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      a_vld_q <= issue;
      b_vld_q <= a_vld_q;
      if (accept) begin
        cnt_q  <= '0;
        live_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (issue) begin
        cnt_q <= cnt_q + fsat_pkg::CNT_W'(1);
      end
      if (b_vld_q) begin
        if (b_expire) begin
          vld_q[b_idx_q] <= 1'b0;
        end
        if (b_live) begin
          live_q <= live_q + fsat_pkg::CNT_W'(1);
          if (!hit_q && b_match_q) begin
            hit_q <= 1'b1;
          end
        end else if (!free_q) begin
          free_q <= 1'b1;
        end
      end
      if (insert) begin
        vld_q[free_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_req_i.key;
      now_q <= in_req_i.now;
    end
    a_idx_q   <= cnt_q[fsat_pkg::IDX_W-1:0];
    b_idx_q   <= a_idx_q;
    b_later_q <= now_q > rd_time;
    b_diff_q  <= now_q - rd_time;
    b_match_q <= rd_key == key_q;
    if (b_vld_q && b_live && !hit_q && b_match_q) begin
      hit_idx_q <= b_idx_q;
    end
    if (b_vld_q && !b_live && !free_q) begin
      free_idx_q <= b_idx_q;
    end
  end

  property p_idle_pipe_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      state_q == fsat_pkg::ST_IDLE |-> !a_vld_q && !b_vld_q;
  endproperty
  a_idle_pipe_empty: assert property (p_idle_pipe_empty)
    else $error("scan pipeline busy while idle");

  property p_insert_free_slot;
    @(posedge clk_i) disable iff (!rst_ni)
      insert |-> !vld_q[free_idx_q] && free_q;
  endproperty
  a_insert_free_slot: assert property (p_insert_free_slot)
    else $error("new session placed over a live slot");

  property p_hit_admits;
    @(posedge clk_i) disable iff (!rst_ni)
      commit && hit_q |-> !res_o.decision && wr_en;
  endproperty
  a_hit_admits: assert property (p_hit_admits)
    else $error("matching session was not refreshed");

  property p_live_matches_bits;
    @(posedge clk_i) disable iff (!rst_ni)
      state_q == fsat_pkg::ST_DECIDE |->
        $countones(vld_q) == int'(live_q);
  endproperty
  a_live_matches_bits: assert property (p_live_matches_bits)
    else $error("live count disagrees with valid bits");

endmodule

// ===== tb/tb_flow_session_admission_table.sv =====
module tb_flow_session_admission_table;

  // Byte addresses of the two configuration registers. The register index
  // sits above the 8-byte alignment bits.
  localparam logic [fsat_pkg::CFG_ADDR_W-1:0] LIMIT_ADDR   = {fsat_pkg::REG_LIMIT, 3'b000};
  localparam logic [fsat_pkg::CFG_ADDR_W-1:0] TIMEOUT_ADDR = {fsat_pkg::REG_TIMEOUT, 3'b000};

  // After the last verdict has arrived, the drain still waits out a margin
  // before configuration is touched.
  localparam int unsigned DRAIN_CYCLES      = fsat_pkg::TABLE_DEPTH + 16;
  localparam int unsigned LONG_HOLD_CYCLES  = 600;
  localparam logic [fsat_pkg::TIME_W-1:0] TIME_MAX = '1;

  // The flow key exactly as it lies in the low 96 bits of s_axis_tdata:
  // source_ident lowest, target_port highest.
  typedef struct packed {
    logic [15:0] target_port;
    logic [15:0] source_port;
    logic [31:0] service_ident;
    logic [31:0] source_ident;
  } flow_key_t;

  // Independent model of the session table. Every accepted request is run
  // through it at once and the verdict it should produce is queued; verdicts
  // from the block are then compared in order against that queue.
  class session_predictor;
    flow_key_t                    slot_key  [fsat_pkg::TABLE_DEPTH];
    logic [fsat_pkg::TIME_W-1:0]  slot_seen [fsat_pkg::TABLE_DEPTH];
    bit                           slot_live [fsat_pkg::TABLE_DEPTH];
    logic [fsat_pkg::LIMIT_W-1:0] limit_reg;
    logic [fsat_pkg::TIME_W-1:0]  timeout_reg;
    fsat_pkg::res_t               pending_verdicts[$];
    int unsigned                  errors;

    function new();
      limit_reg   = fsat_pkg::LIMIT_RST;
      timeout_reg = '0;
      errors      = 0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
    endfunction

    function void write_register(logic [fsat_pkg::CFG_ADDR_W-1:0] addr,
                                 logic [fsat_pkg::CFG_DATA_W-1:0] value);
      case (addr)
        LIMIT_ADDR:   limit_reg   = value[fsat_pkg::LIMIT_W-1:0];
        TIMEOUT_ADDR: timeout_reg = value[fsat_pkg::TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    function void note_request(flow_key_t key, logic [fsat_pkg::TIME_W-1:0] now);
      int             hit;
      int             free_slot;
      int unsigned    live;
      int unsigned    cap;
      fsat_pkg::res_t want;
      hit       = -1;
      free_slot = -1;
      live      = 0;
      cap       = limit_reg;
      if (cap > fsat_pkg::TABLE_DEPTH) cap = fsat_pkg::TABLE_DEPTH;
      // Expiry only applies to sessions seen strictly earlier than now, so a
      // clock that runs backwards never frees anything.
      for (int i = 0; i < fsat_pkg::TABLE_DEPTH; i++) begin
        if (slot_live[i] && now > slot_seen[i] && (now - slot_seen[i]) > timeout_reg)
          slot_live[i] = 1'b0;
        if (slot_live[i]) begin
          live++;
          if (hit < 0 && slot_key[i] == key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      want.decision = 1'b0;
      if (hit >= 0) begin
        slot_seen[hit] = now;
      end else if (live >= cap || free_slot < 0) begin
        want.decision = 1'b1;
      end else begin
        slot_key[free_slot]  = key;
        slot_seen[free_slot] = now;
        slot_live[free_slot] = 1'b1;
        live++;
      end
      want.live = fsat_pkg::LIVE_W'(live);
      pending_verdicts.insert(pending_verdicts.size(), want);
    endfunction

    function void check_verdict(fsat_pkg::res_t got);
      fsat_pkg::res_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: verdict decision=%0d live=%0d arrived with no request outstanding",
                 $time, got.decision, got.live);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.decision !== want.decision) begin
        errors++;
        $display("%0t: decision mismatch, expected %0d, actual %0d",
                 $time, want.decision, got.decision);
      end
      if (got.live !== want.live) begin
        errors++;
        $display("%0t: live_count mismatch, expected %0d, actual %0d",
                 $time, want.live, got.live);
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [159:0]                    s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [7:0]                      m_axis_tdata;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [fsat_pkg::CFG_ADDR_W-1:0] paddr;
  logic [fsat_pkg::CFG_DATA_W-1:0] pwdata;
  logic [fsat_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  session_predictor session_ledger = new();

  // Set for the final phase: from then on neither side idles.
  bit tail_quiet   = 1'b0;
  // Raised by the stimulus to ask the result side for one long hold-off.
  bit hold_request = 1'b0;

  flow_session_admission_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous ceiling: even with every request meeting the longest gap on the
  // sending side, the longest stall on the result side and the full scan, the
  // run needs under a fifth of this.
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side. Verdicts are checked at the edge where they are taken, and
  // tready is then chosen for the next cycle: random stalls, one long hold-off
  // on request, and none at all in the final phase.
  initial begin : verdict_sink
    int unsigned stall_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        session_ledger.check_verdict(fsat_pkg::res_t'(m_axis_tdata));
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && !tail_quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic flow_key_t make_key(logic [31:0] src, logic [31:0] svc,
                                         logic [15:0] sport, logic [15:0] tport);
    flow_key_t k;
    k.source_ident  = src;
    k.service_ident = svc;
    k.source_port   = sport;
    k.target_port   = tport;
    return k;
  endfunction

  function automatic flow_key_t random_key();
    flow_key_t k;
    k = {$urandom, $urandom, $urandom};
    return k;
  endfunction

  // Two-phase write; the register takes the value at the access edge. The
  // setup phase starts at the next edge, so back-to-back writes never drive
  // the bus twice in one step.
  task automatic write_register(logic [fsat_pkg::CFG_ADDR_W-1:0] addr,
                                logic [fsat_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    session_ledger.write_register(addr, value);
  endtask

  // Offers one request, possibly after a random idle burst, and returns at the
  // edge where it was accepted. tvalid is left high so that a following
  // request without a gap goes out back to back.
  task automatic offer_request(flow_key_t key, logic [fsat_pkg::TIME_W-1:0] now);
    if (!tail_quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, key};
    do @(posedge clk_i); while (!s_axis_tready);
    session_ledger.note_request(key, now);
  endtask

  // Stops sending and waits until every verdict is in and the block has had
  // time to finish its write-back, so that configuration may change.
  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    while (session_ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [fsat_pkg::LIMIT_W-1:0] limit,
                           logic [fsat_pkg::TIME_W-1:0] timeout);
    drain_verdicts();
    write_register(LIMIT_ADDR, fsat_pkg::CFG_DATA_W'(limit));
    write_register(TIMEOUT_ADDR, fsat_pkg::CFG_DATA_W'(timeout));
  endtask

  // A random phase. Keys mostly come from a small pool, so that sessions are
  // found again, refreshed, aged out and the table fills up; some pool keys
  // differ from another in a single field to exercise the key comparison.
  // Time mostly advances in small steps, and now and then stands still, runs
  // backwards or jumps anywhere in the 64-bit range.
  task automatic run_phase(logic [fsat_pkg::LIMIT_W-1:0] limit,
                           logic [fsat_pkg::TIME_W-1:0] timeout,
                           int unsigned n_items, int unsigned pool_size,
                           int unsigned step_max, int hold_at);
    flow_key_t                   pool[$];
    flow_key_t                   k;
    logic [fsat_pkg::TIME_W-1:0] clock_ns;
    int unsigned                 pick;
    configure(limit, timeout);
    for (int p = 0; p < pool_size; p++) begin
      if (p > 0 && $urandom_range(0, 2) == 0) begin
        k = pool[$urandom_range(0, p - 1)];
        case ($urandom_range(0, 3))
          0:       k.source_ident  = $urandom;
          1:       k.service_ident = $urandom;
          2:       k.source_port   = 16'($urandom);
          default: k.target_port   = 16'($urandom);
        endcase
      end else begin
        k = random_key();
      end
      pool.insert(pool.size(), k);
    end
    clock_ns = {$urandom, $urandom};
    for (int n = 0; n < n_items; n++) begin
      if (n == hold_at) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 80)      clock_ns += $urandom_range(0, step_max);
      else if (pick < 88) clock_ns = clock_ns;
      else if (pick < 95) clock_ns -= $urandom_range(1, 4 * step_max);
      else                clock_ns = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 88) k = pool[$urandom_range(0, pool_size - 1)];
      else                            k = random_key();
      offer_request(k, clock_ns);
    end
  endtask

  initial begin : stimulus
    flow_key_t ka, kb, kc, kd, ke, k_zero, k_ones;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Keys B to E each differ from A in one field only.
    ka     = make_key(32'h0000_0001, 32'h0000_0010, 16'd1024, 16'd80);
    kb     = make_key(32'h0000_0001, 32'h0000_0010, 16'd1024, 16'd443);
    kc     = make_key(32'h0000_0002, 32'h0000_0010, 16'd1024, 16'd80);
    kd     = make_key(32'h0000_0001, 32'h0000_0011, 16'd1024, 16'd80);
    ke     = make_key(32'h0000_0001, 32'h0000_0010, 16'd1025, 16'd80);
    k_zero = '0;
    k_ones = '1;

    configure(7'd3, 64'd100);
    offer_request(ka, 64'd1000);
    offer_request(ka, 64'd1050);      // known session is refreshed
    offer_request(kb, 64'd1060);
    offer_request(kc, 64'd1070);      // live count now at the limit
    offer_request(kd, 64'd1080);      // limit reached: rejected
    offer_request(kd, 64'd1200);      // A, B and C have aged out
    offer_request(ke, 64'd500);       // clock ran backwards: D must survive
    offer_request(kd, 64'd0);         // a match still takes the earlier time
    offer_request(k_zero, TIME_MAX);  // both older sessions expire
    offer_request(k_ones, TIME_MAX);  // equal time does not free the zero key
    offer_request(k_ones, TIME_MAX);

    // With a zero limit only existing sessions get through.
    configure(7'd0, 64'd100);
    offer_request(ka, TIME_MAX);
    offer_request(k_zero, TIME_MAX);

    // Limit beyond the table depth and a timeout that can never be exceeded.
    configure(7'd127, TIME_MAX);
    offer_request(kb, 64'd5);
    offer_request(kc, 64'd6);
    offer_request(ka, 64'd7);

    // Zero timeout: anything seen strictly earlier is gone.
    configure(7'd64, 64'd0);
    offer_request(ka, 64'd7);
    offer_request(kd, 64'd8);

    // Random part, one phase per configuration.
    run_phase(7'd64,  64'd2000, 220, 80, 60, -1);
    run_phase(7'd127, TIME_MAX, 180, 90, 50, -1);
    run_phase(7'd0,   64'd300,  100, 20, 40, -1);
    run_phase(7'd5,   64'd300,  200, 12, 40, -1);
    run_phase(7'd40,  64'd0,    200, 30, 3,  -1);
    // The long hold-off lands in this phase while requests keep coming, so
    // the block fills up and refuses further requests for a while.
    run_phase(7'd100, 64'd5000, 220, 70, 40, 50);
    tail_quiet = 1'b1;
    run_phase(7'd64, 64'($urandom_range(200, 3000)), 260, 50, 40, -1);

    drain_verdicts();
    if (session_ledger.errors == 0 && session_ledger.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fsat_pkg.sv
rtl/fsat_ram.sv
rtl/fsat_cfg.sv
rtl/fsat_scan.sv
rtl/flow_session_admission_table.sv
tb/tb_flow_session_admission_table.sv
